>>> design/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared codes, widths and controller/datapath signal groups for the matrix
// multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

    // request codes
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_A_ROWS     = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_B_COLS     = 2'd2;

    // fixed field widths
    localparam int ACTION_BITS  = 2;
    localparam int INDEX_BITS   = 6;
    localparam int ELEM_BITS    = 16;
    localparam int OUT_BITS     = 35;
    localparam int IDX_BITS     = 3;
    localparam int DIM_BITS     = 4;
    localparam int CFG_IDX_BITS = 2;

    // reset value of every size register
    localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                wr_a;
        logic                wr_b;
        logic                rd_en;
        logic                first;
        logic                last_term;
        logic                push;
        logic                last_elem;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [IDX_BITS-1:0] k;
        logic [DIM_BITS-1:0] inner;
        logic [DIM_BITS-1:0] cols;
    } mm_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic sum_ready;
        logic out_free;
    } mm_status_t;

endpackage

>>> design/mm_if.sv
// ----------------------------------------------------------------------------
// mm_if
// Request and result channels of the matrix multiply block.
// ----------------------------------------------------------------------------
interface mm_in_if;
    import mm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [ACTION_BITS-1:0]        action;
    logic [INDEX_BITS-1:0]         elem_index;
    logic signed [ELEM_BITS-1:0]   elem_value;

    modport source (output valid, output action, output elem_index, output elem_value,
                    input ready);
    modport sink   (input valid, input action, input elem_index, input elem_value,
                    output ready);
endinterface

interface mm_out_if;
    import mm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_BITS-1:0]  product_value;
    logic [IDX_BITS-1:0]         out_row;
    logic [IDX_BITS-1:0]         out_col;
    logic                        last;

    modport source (output valid, output product_value, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input product_value, input out_row, input out_col,
                    input last, output ready);
endinterface

>>> design/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// General matrix multiply over two loaded element stores.
// ----------------------------------------------------------------------------
// Requests load elements of A and B or start a run. A run emits
// a_rows * b_cols product elements in row-major order, each the exact
// Q19.16 sum of inner_size Q8.8 products, formed in the single shared
// multiply-accumulate pipeline (store read, multiply register, accumulate
// register). Each element starts after the previous sum is pushed to the
// output register, held off while the result stalls. No request is taken
// during a run. Stores are not cleared: read only entries that were loaded.
module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int VALUE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mm_in_if.sink                            item,
    mm_out_if.source                         result,
    input  logic                             cfg_we,
    input  logic [mm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mm_pkg::DIM_BITS-1:0]      cfg_data
);
    import mm_pkg::*;

    mm_cmd_t    cmd;
    mm_status_t status;

    mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .action    (item.action),
        .cmd       (cmd),
        .status    (status)
    );

    mm_datapath #(.MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_index (item.elem_index),
        .elem_value (item.elem_value),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

endmodule

>>> design/mm_ram.sv
// ----------------------------------------------------------------------------
// mm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl
// Size registers and run sequencer: walks row, column and inner index and
// issues one multiply-accumulate term per cycle except while a sum waits.
// ----------------------------------------------------------------------------
module mm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mm_pkg::DIM_BITS-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mm_pkg::ACTION_BITS-1:0]      action,
    output mm_pkg::mm_cmd_t                     cmd,
    input  mm_pkg::mm_status_t                  status
);
    import mm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} state_t;

    localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIM);
    localparam logic [DIM_BITS-1:0] DIM_ONE = DIM_BITS'(1);

    state_t              state_reg, state_next;
    logic [DIM_BITS-1:0] a_rows_reg, inner_size_reg, b_cols_reg;
    logic [DIM_BITS-1:0] rows_reg, rows_next;
    logic [DIM_BITS-1:0] inner_reg, inner_next;
    logic [DIM_BITS-1:0] cols_reg, cols_next;
    logic [IDX_BITS-1:0] i_reg, i_next;
    logic [IDX_BITS-1:0] j_reg, j_next;
    logic [IDX_BITS-1:0] k_reg, k_next;
    logic                accept;
    logic                k_last, j_last, i_last;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
        if (d == '0)
            return DIM_ONE;
        else if (d > DIM_MAX)
            return DIM_MAX;
        else
            return d;
    endfunction

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg     <= DIM_RESET;
            inner_size_reg <= DIM_RESET;
            b_cols_reg     <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_A_ROWS:     a_rows_reg     <= cfg_data;
                CFG_INNER_SIZE: inner_size_reg <= cfg_data;
                CFG_B_COLS:     b_cols_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // loop end flags
    assign k_last = ({1'b0, k_reg} == inner_reg - DIM_ONE);
    assign j_last = ({1'b0, j_reg} == cols_reg - DIM_ONE);
    assign i_last = ({1'b0, i_reg} == rows_reg - DIM_ONE);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && action == ACT_RUN)
                begin
                    rows_next  = clamp_dim(a_rows_reg);
                    inner_next = clamp_dim(inner_size_reg);
                    cols_next  = clamp_dim(b_cols_reg);
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = S_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_BITS'(1);
                end
            end
            S_WAIT:
            begin
                if (status.sum_ready && status.out_free)
                begin
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_BITS'(1);
                            state_next = S_ISSUE;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_BITS'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rows_reg  <= DIM_ONE;
            inner_reg <= DIM_ONE;
            cols_reg  <= DIM_ONE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.wr_a      = accept && (action == ACT_LOAD_A);
        cmd.wr_b      = accept && (action == ACT_LOAD_B);
        cmd.rd_en     = (state_reg == S_ISSUE);
        cmd.first     = (k_reg == '0);
        cmd.last_term = k_last;
        cmd.push      = (state_reg == S_WAIT) && status.sum_ready && status.out_free;
        cmd.last_elem = i_last && j_last;
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.k         = k_reg;
        cmd.inner     = inner_reg;
        cmd.cols      = cols_reg;
    end

    // a new term never starts while a finished sum still waits
    a_no_issue_on_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !status.sum_ready)
        else $error("term issued while a finished sum waits");

    // a run request starts issuing terms in the next cycle
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_RUN) |=> cmd.rd_en && cmd.first)
        else $error("run request did not start the sequencer");

    // pushing the final element returns the block to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cmd.last_elem) |=> in_ready)
        else $error("block not idle after final element");

endmodule

>>> design/mm_datapath.sv
// ----------------------------------------------------------------------------
// mm_datapath
// Element stores, address generation, multiply-accumulate pipeline and
// result output register.
// ----------------------------------------------------------------------------
module mm_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int VALUE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [mm_pkg::INDEX_BITS-1:0]         elem_index,
    input  logic signed [mm_pkg::ELEM_BITS-1:0]   elem_value,
    input  mm_pkg::mm_cmd_t                       cmd,
    output mm_pkg::mm_status_t                    status,
    mm_out_if.source                              result
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int AFW   = IDX_BITS + DIM_BITS;
    localparam int PW    = 2 * VALUE_BITS;

    logic [VALUE_BITS-1:0]        wr_value;
    logic                         in_range;
    logic [AFW-1:0]               a_addr_full, b_addr_full;
    logic [VALUE_BITS-1:0]        a_data, b_data;
    logic                         p1_valid_reg, p1_first_reg, p1_last_reg;
    logic                         p2_valid_reg, p2_first_reg, p2_last_reg;
    logic signed [PW-1:0]         prod_reg;
    logic [OUT_BITS-1:0]          prod_ext;
    logic [OUT_BITS-1:0]          acc_reg;
    logic                         sum_ready_reg;
    logic                         out_valid_reg;
    logic [OUT_BITS-1:0]          out_value_reg;
    logic [IDX_BITS-1:0]          out_row_reg, out_col_reg;
    logic                         out_last_reg;

    // fit the loaded value to the store width
    generate
        if (VALUE_BITS <= ELEM_BITS)
        begin : g_trunc
            assign wr_value = elem_value[VALUE_BITS-1:0];
        end
        else
        begin : g_sext
            assign wr_value = {{(VALUE_BITS-ELEM_BITS){elem_value[ELEM_BITS-1]}}, elem_value};
        end
    endgenerate

    assign in_range = (int'(elem_index) < DEPTH);

    // row-major read addresses
    assign a_addr_full = AFW'(cmd.row) * AFW'(cmd.inner) + AFW'(cmd.k);
    assign b_addr_full = AFW'(cmd.k) * AFW'(cmd.cols) + AFW'(cmd.col);

    mm_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_a_store (
        .clk     (clk),
        .wr_en   (cmd.wr_a && in_range),
        .wr_addr (elem_index[AW-1:0]),
        .wr_data (wr_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (a_addr_full[AW-1:0]),
        .rd_data (a_data)
    );

    mm_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_b_store (
        .clk     (clk),
        .wr_en   (cmd.wr_b && in_range),
        .wr_addr (elem_index[AW-1:0]),
        .wr_data (wr_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (b_addr_full[AW-1:0]),
        .rd_data (b_data)
    );

    // pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.rd_en;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_first_reg <= cmd.first;
        p1_last_reg  <= cmd.last_term;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            prod_reg <= $signed(a_data) * $signed(b_data);
        end
    end

    // product at result width, wrapping when wider
    generate
        if (PW >= OUT_BITS)
        begin : g_prod_cut
            assign prod_ext = prod_reg[OUT_BITS-1:0];
        end
        else
        begin : g_prod_ext
            assign prod_ext = {{(OUT_BITS-PW){prod_reg[PW-1]}}, prod_reg};
        end
    endgenerate

    // accumulate stage
    always_ff @(posedge clk)
    begin
        if (p2_valid_reg)
        begin
            acc_reg <= (p2_first_reg ? '0 : acc_reg) + prod_ext;
        end
    end

    // finished sum flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_ready_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            sum_ready_reg <= 1'b0;
        end
        else if (p2_valid_reg && p2_last_reg)
        begin
            sum_ready_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_value_reg <= acc_reg;
            out_row_reg   <= cmd.row;
            out_col_reg   <= cmd.col;
            out_last_reg  <= cmd.last_elem;
        end
    end

    assign status.sum_ready = sum_ready_reg;
    assign status.out_free  = !out_valid_reg || result.ready;

    assign result.valid         = out_valid_reg;
    assign result.product_value = out_value_reg;
    assign result.out_row       = out_row_reg;
    assign result.out_col       = out_col_reg;
    assign result.last          = out_last_reg;

    // no term reaches the accumulator while a finished sum waits
    a_no_term_on_sum: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> !sum_ready_reg)
        else $error("term accumulated over a finished sum");

    // a completed sum always comes from a final term
    a_sum_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sum_ready_reg) |-> $past(p2_valid_reg && p2_last_reg))
        else $error("sum flagged without a final term");

endmodule

>>> tb/sv/matrix_multiply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_test
// Loads A and B element by element, starts runs under a range of sizes and
// checks every product element, with its row, column and last flag, against
// a local prediction of the exact Q19.16 sums. Sender and result side idle
// and stall at random in several phases.
// ----------------------------------------------------------------------------
module matrix_multiply_test;
    import mm_pkg::*;

    localparam int MAX_DIM       = 8;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 5000;
    localparam int PHASE_ITEMS   = 85;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
    localparam logic [ELEM_BITS-1:0]   VAL_MIN    = 16'h8000;
    localparam logic [ELEM_BITS-1:0]   VAL_MAX    = 16'h7FFF;

    // how the elements of one load sequence are chosen
    typedef enum {FILL_RANDOM, FILL_MIN, FILL_EXTREME, FILL_OPPOSED} fill_t;

    typedef struct {
        logic signed [OUT_BITS-1:0] value;
        logic [IDX_BITS-1:0]        row;
        logic [IDX_BITS-1:0]        col;
        logic                       last;
    } product_t;

    // shadow stores, sizes and the queue of product elements still due
    class product_tracker;
        logic signed [ELEM_BITS-1:0] a_vals[STORE_DEPTH];
        logic signed [ELEM_BITS-1:0] b_vals[STORE_DEPTH];
        logic [DIM_BITS-1:0]         a_rows;
        logic [DIM_BITS-1:0]         inner_size;
        logic [DIM_BITS-1:0]         b_cols;
        product_t                    pending[$];
        int                          errors;

        function new();
            a_rows     = DIM_RESET;
            inner_size = DIM_RESET;
            b_cols     = DIM_RESET;
            errors     = 0;
            foreach (a_vals[n])
            begin
                a_vals[n] = '0;
                b_vals[n] = '0;
            end
        endfunction

        function int clamp_dim(logic [DIM_BITS-1:0] d);
            if (d == 0)
                return 1;
            if (d > MAX_DIM)
                return MAX_DIM;
            return d;
        endfunction

        function void set_size(logic [CFG_IDX_BITS-1:0] index, logic [DIM_BITS-1:0] d);
            case (index)
                CFG_A_ROWS:     a_rows = d;
                CFG_INNER_SIZE: inner_size = d;
                CFG_B_COLS:     b_cols = d;
                default: ;
            endcase
        endfunction

        // every element of A * B in row-major order
        function void predict_run();
            int       rows;
            int       inner;
            int       cols;
            longint   acc;
            product_t p;
            rows  = clamp_dim(a_rows);
            inner = clamp_dim(inner_size);
            cols  = clamp_dim(b_cols);
            for (int i = 0; i < rows; i++)
            begin
                for (int j = 0; j < cols; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < inner; k++)
                        acc += longint'(a_vals[i * inner + k]) * longint'(b_vals[k * cols + j]);
                    p.value = acc[OUT_BITS-1:0];
                    p.row   = i[IDX_BITS-1:0];
                    p.col   = j[IDX_BITS-1:0];
                    p.last  = (i == rows - 1) && (j == cols - 1);
                    pending.push_back(p);
                end
            end
        endfunction

        function void note_request(logic [ACTION_BITS-1:0] act, logic [INDEX_BITS-1:0] idx,
                                   logic [ELEM_BITS-1:0] val);
            case (act)
                ACT_LOAD_A: a_vals[idx] = val;
                ACT_LOAD_B: b_vals[idx] = val;
                ACT_RUN:    predict_run();
                default: ;
            endcase
        endfunction

        function void check_product(logic signed [OUT_BITS-1:0] value, logic [IDX_BITS-1:0] row,
                                    logic [IDX_BITS-1:0] col, logic last);
            product_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected product: value %0d row %0d col %0d last %0b",
                             value, row, col, last);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value || row !== want.row || col !== want.col
                || last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("product mismatch: expected %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
                             want.value, want.row, want.col, want.last, value, row, col, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [DIM_BITS-1:0]     cfg_data;

    mm_in_if  item_ch();
    mm_out_if result_ch();

    product_tracker tracker;
    logic a_loaded[STORE_DEPTH];
    logic b_loaded[STORE_DEPTH];
    int   item_count;
    int   send_idle_pct;
    int   stall_pct;
    int   quiet_cycles;

    matrix_multiply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // result side: check accepted products, then choose the next ready
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.check_product(result_ch.product_value, result_ch.out_row,
                                  result_ch.out_col, result_ch.last);
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no accepted request, product or register write
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("matrix_multiply_test: errors");
            $finish;
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send_request(input logic [ACTION_BITS-1:0] act,
                                input logic [INDEX_BITS-1:0] idx,
                                input logic [ELEM_BITS-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.elem_index <= idx;
        item_ch.elem_value <= val;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        tracker.note_request(act, idx, val);
        if (act == ACT_LOAD_A)
            a_loaded[idx] = 1'b1;
        if (act == ACT_LOAD_B)
            b_loaded[idx] = 1'b1;
        if (act != ACT_UNUSED)
            item_count++;
    endtask

    // drain all products, let the block go idle
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new sizes, written only while idle
    task automatic resize(input logic [DIM_BITS-1:0] r, input logic [DIM_BITS-1:0] i,
                          input logic [DIM_BITS-1:0] c);
        logic [CFG_IDX_BITS-1:0] reg_order[3];
        logic [DIM_BITS-1:0]     sizes[3];
        reg_order = '{CFG_A_ROWS, CFG_INNER_SIZE, CFG_B_COLS};
        sizes     = '{r, i, c};
        settle();
        for (int n = 0; n < 3; n++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_order[n];
            cfg_data  <= sizes[n];
            @(posedge clk);
            tracker.set_size(reg_order[n], sizes[n]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ELEM_BITS-1:0] pick_value(fill_t fill, logic is_b);
        case (fill)
            FILL_MIN:     return VAL_MIN;
            FILL_OPPOSED: return is_b ? VAL_MAX : VAL_MIN;
            FILL_EXTREME: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default:
            begin
                if ($urandom_range(99) < 15)
                    return $urandom_range(1) ? VAL_MAX : VAL_MIN;
                return ELEM_BITS'($urandom_range(65535));
            end
        endcase
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        if (r < 14)
            return DIM_BITS'($urandom_range(8, 15));
        return DIM_BITS'($urandom_range(1, 4));
    endfunction

    // occasional stray request: unused action or a load anywhere
    task automatic maybe_noise();
        if ($urandom_range(99) < 8)
        begin
            case ($urandom_range(2))
                0: send_request(ACT_UNUSED, INDEX_BITS'($urandom_range(63)),
                                ELEM_BITS'($urandom_range(65535)));
                1: send_request(ACT_LOAD_A, INDEX_BITS'($urandom_range(63)),
                                ELEM_BITS'($urandom_range(65535)));
                default: send_request(ACT_LOAD_B, INDEX_BITS'($urandom_range(63)),
                                      ELEM_BITS'($urandom_range(65535)));
            endcase
        end
    endtask

    // load each unloaded entry the current sizes read, and others, then run
    task automatic run_job(input fill_t fill);
        int rows;
        int inner;
        int cols;
        rows  = tracker.clamp_dim(tracker.a_rows);
        inner = tracker.clamp_dim(tracker.inner_size);
        cols  = tracker.clamp_dim(tracker.b_cols);
        for (int n = 0; n < rows * inner; n++)
        begin
            if (!a_loaded[n] || fill != FILL_RANDOM || $urandom_range(99) < 30)
            begin
                maybe_noise();
                send_request(ACT_LOAD_A, INDEX_BITS'(n), pick_value(fill, 1'b0));
            end
        end
        for (int n = 0; n < inner * cols; n++)
        begin
            if (!b_loaded[n] || fill != FILL_RANDOM || $urandom_range(99) < 30)
            begin
                maybe_noise();
                send_request(ACT_LOAD_B, INDEX_BITS'(n), pick_value(fill, 1'b1));
            end
        end
        maybe_noise();
        send_request(ACT_RUN, INDEX_BITS'($urandom_range(63)), ELEM_BITS'($urandom_range(65535)));
        if ($urandom_range(99) < 10)
            send_request(ACT_RUN, INDEX_BITS'($urandom_range(63)),
                         ELEM_BITS'($urandom_range(65535)));
    endtask

    initial
    begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int target;
        idle_by_phase  = '{0, 85, 0, 38};
        stall_by_phase = '{0, 0, 85, 38};
        tracker = new();
        foreach (a_loaded[n])
        begin
            a_loaded[n] = 1'b0;
            b_loaded[n] = 1'b0;
        end
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.action     = '0;
        item_ch.elem_index = '0;
        item_ch.elem_value = '0;
        result_ch.ready    = 1'b0;
        item_count         = 0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        quiet_cycles       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sizes of zero count as one: single products at the value extremes
        resize('0, '0, '0);
        send_request(ACT_LOAD_A, 0, VAL_MIN);
        send_request(ACT_LOAD_B, 0, VAL_MIN);
        send_request(ACT_RUN, 0, '0);
        send_request(ACT_LOAD_A, 0, VAL_MAX);
        send_request(ACT_RUN, 63, 16'hFFFF);
        // unused action, top index, zero and one
        send_request(ACT_UNUSED, 63, 16'h7FFF);
        send_request(ACT_LOAD_A, 63, VAL_MAX);
        send_request(ACT_LOAD_B, 63, 16'hFFFF);
        send_request(ACT_LOAD_A, 0, '0);
        send_request(ACT_LOAD_B, 0, 16'h0001);
        send_request(ACT_RUN, 0, '0);

        // largest sums of both signs: inner size above the maximum
        resize(4'd1, 4'd15, 4'd1);
        run_job(FILL_MIN);
        run_job(FILL_OPPOSED);
        // full 8 x 8 product from a single inner term
        resize(4'd15, 4'd1, 4'd8);
        run_job(FILL_RANDOM);

        // random sizes and load sequences under each idling phase
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            target        = item_count + PHASE_ITEMS;
            while (item_count < target)
            begin
                resize(pick_dim(), pick_dim(), pick_dim());
                repeat ($urandom_range(1, 3))
                    run_job(($urandom_range(99) < 8) ? FILL_EXTREME : FILL_RANDOM);
            end
        end

        settle();
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("matrix_multiply_test: clean");
        else
            $display("matrix_multiply_test: errors");
        $finish;
    end
endmodule
